FILE: rtl/bga_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bga_pkg
// Shared types and constants for the binary grid automaton step block.
// ----------------------------------------------------------------------------
package bga_pkg;

    localparam int GRID_COLUMNS = 64;
    localparam int GRID_ROWS    = 64;

    localparam int ADDR_W = (GRID_COLUMNS > 1) ? $clog2(GRID_COLUMNS) : 1;
    // step counter of one generation runs 0 .. GRID_COLUMNS+1
    localparam int STEP_W = $clog2(GRID_COLUMNS + 2);

    localparam int WORD_W  = 64;
    localparam int INDEX_W = 6;
    localparam int CFG_W   = 4;

    localparam logic [WORD_W-1:0] ROW_MASK =
        (GRID_ROWS >= WORD_W) ? {WORD_W{1'b1}} : ((64'd1 << GRID_ROWS) - 64'd1);

    typedef enum logic [1:0] {
        CFG_GENERATIONS = 2'd0,
        CFG_DEATH_LIMIT = 2'd1,
        CFG_BIRTH_LIMIT = 2'd2,
        CFG_EDGE_ALIVE  = 2'd3
    } cfg_index_t;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_RUN   = 1'b1
    } cmd_t;

    typedef struct packed {
        logic                cmd;
        logic [INDEX_W-1:0]  column_index;
        logic [WORD_W-1:0]   column_bits;
    } in_item_t;

    typedef struct packed {
        logic [INDEX_W-1:0]  out_index;
        logic [WORD_W-1:0]   out_bits;
        logic                last_column;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GEN,
        ST_DUMP_RD,
        ST_DUMP_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic              load_en;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              win_init;
        logic              shift_en;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic              right_edge;
    } dp_cmd_t;

    typedef struct packed {
        logic [CFG_W-1:0] generations;
        logic [CFG_W-1:0] death_limit;
        logic [CFG_W-1:0] birth_limit;
        logic             edge_alive;
    } cfg_t;

endpackage : bga_pkg
`default_nettype wire

FILE: rtl/bga_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bga_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module bga_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic                                     re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule : bga_ram
`default_nettype wire

FILE: rtl/bga_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bga_ctrl
// Sequencer: column loads, generation sweeps and the column dump.
// ----------------------------------------------------------------------------
module bga_ctrl
    import bga_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       in_cmd,
    input  wire logic       out_ready,
    output logic            out_valid,
    input  wire logic [CFG_W-1:0] generations,
    output dp_cmd_t         dp_cmd
);

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(GRID_COLUMNS + 1);
    localparam logic [STEP_W-1:0] STEP_COLS = STEP_W'(GRID_COLUMNS);
    localparam logic [ADDR_W-1:0] COL_LAST  = ADDR_W'(GRID_COLUMNS - 1);

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [CFG_W-1:0]  gen_left_reg, gen_left_next;
    logic [ADDR_W-1:0] col_reg, col_next;
    logic [STEP_W-1:0] wr_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            gen_left_reg <= '0;
            col_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            gen_left_reg <= gen_left_next;
            col_reg      <= col_next;
        end
    end

    assign wr_step = step_reg - STEP_W'(2);

    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        gen_left_next = gen_left_reg;
        col_next      = col_reg;
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        dp_cmd        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_cmd == CMD_WRITE)
                    begin
                        dp_cmd.load_en = 1'b1;
                    end
                    else if (generations != '0)
                    begin
                        gen_left_next = generations;
                        step_next     = '0;
                        state_next    = ST_GEN;
                    end
                    else
                    begin
                        col_next   = '0;
                        state_next = ST_DUMP_RD;
                    end
                end
            end

            // each step reads one column and shifts the word returned by the registered
            // read into the window; the column two before the one read is written back
            ST_GEN:
            begin
                dp_cmd.rd_en      = (step_reg < STEP_COLS);
                dp_cmd.rd_addr    = step_reg[ADDR_W-1:0];
                dp_cmd.win_init   = (step_reg == '0);
                dp_cmd.shift_en   = (step_reg != '0) && (step_reg <= STEP_COLS);
                dp_cmd.wr_en      = (step_reg >= STEP_W'(2));
                dp_cmd.wr_addr    = wr_step[ADDR_W-1:0];
                dp_cmd.right_edge = (step_reg == STEP_LAST);
                if (step_reg == STEP_LAST)
                begin
                    step_next = '0;
                    if (gen_left_reg == CFG_W'(1))
                    begin
                        col_next   = '0;
                        state_next = ST_DUMP_RD;
                    end
                    else
                    begin
                        gen_left_next = gen_left_reg - CFG_W'(1);
                    end
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end

            ST_DUMP_RD:
            begin
                dp_cmd.rd_en   = 1'b1;
                dp_cmd.rd_addr = col_reg;
                state_next     = ST_DUMP_OUT;
            end

            ST_DUMP_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (col_reg == COL_LAST)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        col_next   = col_reg + ADDR_W'(1);
                        state_next = ST_DUMP_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule : bga_ctrl
`default_nettype wire

FILE: rtl/bga_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bga_datapath
// Grid store, per-column valid bits, three-column window and cell update.
// ----------------------------------------------------------------------------
module bga_datapath
    import bga_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire dp_cmd_t  dp_cmd,
    input  wire cfg_t     cfg,
    input  wire in_item_t in_item,
    output out_item_t     out_item
);

    localparam logic [ADDR_W-1:0] COL_LAST = ADDR_W'(GRID_COLUMNS - 1);

    logic [GRID_COLUMNS-1:0] valid_reg;
    logic                    rvalid_reg;
    logic [INDEX_W-1:0]      out_index_reg;
    logic                    last_reg;
    logic [GRID_ROWS-1:0]    left_reg;
    logic [GRID_ROWS-1:0]    mid_reg;

    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr;
    logic [WORD_W-1:0]       ram_wdata;
    logic [WORD_W-1:0]       ram_rdata;
    logic [WORD_W-1:0]       col_word;
    logic [GRID_ROWS-1:0]    edge_fill;
    logic [GRID_ROWS-1:0]    right_col;
    logic [GRID_ROWS-1:0]    new_col;
    logic                    load_ok;

    function automatic logic [GRID_ROWS-1:0] next_column(
        input logic [GRID_ROWS-1:0] col_l,
        input logic [GRID_ROWS-1:0] col_m,
        input logic [GRID_ROWS-1:0] col_r,
        input logic                 edge_bit,
        input logic [CFG_W-1:0]     death,
        input logic [CFG_W-1:0]     birth
    );
        logic [GRID_ROWS+1:0] l;
        logic [GRID_ROWS+1:0] m;
        logic [GRID_ROWS+1:0] r;
        logic [3:0]           cnt;
        logic [GRID_ROWS-1:0] res;
        l = {edge_bit, col_l, edge_bit};
        m = {edge_bit, col_m, edge_bit};
        r = {edge_bit, col_r, edge_bit};
        res = '0;
        for (int y = 0; y < GRID_ROWS; y++)
        begin
            cnt = {3'b000, l[y]} + {3'b000, l[y+1]} + {3'b000, l[y+2]}
                + {3'b000, m[y]} + {3'b000, m[y+2]}
                + {3'b000, r[y]} + {3'b000, r[y+1]} + {3'b000, r[y+2]};
            if (m[y+1])
            begin
                res[y] = (cnt >= death);
            end
            else
            begin
                res[y] = (cnt > birth);
            end
        end
        return res;
    endfunction

    assign load_ok   = dp_cmd.load_en
                     && ({1'b0, in_item.column_index} < (INDEX_W + 1)'(GRID_COLUMNS));
    assign ram_we    = load_ok || dp_cmd.wr_en;
    assign ram_waddr = dp_cmd.load_en ? in_item.column_index[ADDR_W-1:0] : dp_cmd.wr_addr;
    assign ram_wdata = dp_cmd.load_en ? (in_item.column_bits & ROW_MASK)
                                      : WORD_W'(new_col);

    bga_ram #(
        .WIDTH (WORD_W),
        .DEPTH (GRID_COLUMNS)
    ) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (dp_cmd.rd_en),
        .raddr (dp_cmd.rd_addr),
        .rdata (ram_rdata)
    );

    // a column never written since reset reads as all dead
    assign col_word  = rvalid_reg ? ram_rdata : '0;
    assign edge_fill = {GRID_ROWS{cfg.edge_alive}};
    assign right_col = dp_cmd.right_edge ? edge_fill : col_word[GRID_ROWS-1:0];
    assign new_col   = next_column(left_reg, mid_reg, right_col, cfg.edge_alive,
                                   cfg.death_limit, cfg.birth_limit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ram_we)
        begin
            valid_reg[ram_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.rd_en)
        begin
            rvalid_reg    <= valid_reg[dp_cmd.rd_addr];
            out_index_reg <= INDEX_W'(dp_cmd.rd_addr);
            last_reg      <= (dp_cmd.rd_addr == COL_LAST);
        end
        if (dp_cmd.win_init)
        begin
            mid_reg <= edge_fill;
        end
        else if (dp_cmd.shift_en)
        begin
            left_reg <= mid_reg;
            mid_reg  <= col_word[GRID_ROWS-1:0];
        end
    end

    assign out_item.out_index   = out_index_reg;
    assign out_item.out_bits    = col_word & ROW_MASK;
    assign out_item.last_column = last_reg;

endmodule : bga_datapath
`default_nettype wire

FILE: rtl/binary_grid_automaton_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// binary_grid_automaton_step
// Birth/death-limit cellular automaton over a loaded binary grid.
// ----------------------------------------------------------------------------
// A write request (cmd 0) stores one column word and the block is ready
// again on the next cycle. A run request (cmd 1) sweeps the grid once
// per generation through the grid memory with a three-column window, reading
// one column and writing back an earlier one in the same cycle. It then
// dumps every column in index order, each as a memory read followed by the
// result held until taken. No new request is accepted until the last column
// of the dump is taken. Columns never written since reset read as all dead.
module binary_grid_automaton_step
    import bga_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire in_item_t         in_item,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output out_item_t             out_item,
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data
);

    cfg_t    cfg_reg;
    dp_cmd_t dp_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.generations <= CFG_W'(2);
            cfg_reg.death_limit <= CFG_W'(4);
            cfg_reg.birth_limit <= CFG_W'(4);
            cfg_reg.edge_alive  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_GENERATIONS: cfg_reg.generations <= cfg_data;
                CFG_DEATH_LIMIT: cfg_reg.death_limit <= cfg_data;
                CFG_BIRTH_LIMIT: cfg_reg.birth_limit <= cfg_data;
                CFG_EDGE_ALIVE:  cfg_reg.edge_alive  <= cfg_data[0];
                default:         cfg_reg.edge_alive  <= cfg_reg.edge_alive;
            endcase
        end
    end

    bga_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_cmd      (in_item.cmd),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .generations (cfg_reg.generations),
        .dp_cmd      (dp_cmd)
    );

    bga_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .dp_cmd   (dp_cmd),
        .cfg      (cfg_reg),
        .in_item  (in_item),
        .out_item (out_item)
    );

    // results only while no request can be taken
    a_out_blocks_in : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("result shown while input ready");

    a_last_index : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.last_column)
            |-> (out_item.out_index == INDEX_W'(GRID_COLUMNS - 1)))
        else $error("last_column on wrong index");

    a_dump_done : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && out_item.last_column) |=> in_ready)
        else $error("not ready after dump end");

    a_run_busy : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (in_item.cmd == CMD_RUN)) |=> !in_ready)
        else $error("ready right after run request");

endmodule : binary_grid_automaton_step
`default_nettype wire
